>>> rtl/btpm_pkg.sv
// -----------------------------------------------------------------------------
// btpm_pkg
// Shared constants and types of the binary trie prefix matcher.
// -----------------------------------------------------------------------------
package btpm_pkg;

   localparam int NODES     = 1024;
   localparam int ADDR_BITS = 32;

   localparam int IDX_W  = $clog2(NODES);
   localparam int FREE_W = $clog2(NODES + 1);
   localparam int LVL_W  = $clog2(ADDR_BITS + 1);
   localparam int REQ_ADDR_W = 32;
   localparam int PLEN_W     = 6;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] child0;
      logic [IDX_W-1:0] child1;
      logic             mark;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic                 func;
      logic [ADDR_BITS-1:0] addr;
      logic [LVL_W-1:0]     limit;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic found;
      logic full;
   } res_type;

endpackage

>>> rtl/btpm_ram.sv
// -----------------------------------------------------------------------------
// btpm_ram
// Generic single-port synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
module btpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/btpm_walk.sv
// -----------------------------------------------------------------------------
// btpm_walk
// Trie walk sequencer: one level per cycle through the node memory (an insert
// pauses in ST_LINK for the parent link write-back), plus node allocation and prefix marking.
// -----------------------------------------------------------------------------
module btpm_walk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  btpm_pkg::cmd_type          cmd,
   input  logic                       ack,
   output btpm_pkg::res_type          res,
   output logic                       ram_we,
   output logic [btpm_pkg::IDX_W-1:0] ram_addr,
   output logic [btpm_pkg::NODE_W-1:0] ram_wdata,
   input  logic [btpm_pkg::NODE_W-1:0] ram_rdata
);
   import btpm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_LINK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic                 func_ff, func_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [LVL_W-1:0]     limit_ff, limit_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic [IDX_W-1:0]     cur_idx_ff, cur_idx_in;
   node_type             cur_word_ff, cur_word_in;
   logic                 rd_pend_ff, rd_pend_in;
   node_type             link_word_ff, link_word_in;
   logic [IDX_W-1:0]     link_idx_ff, link_idx_in;
   node_type             root_ff, root_in;
   logic [FREE_W-1:0]    next_free_ff, next_free_in;
   logic                 found_ff, found_in;
   logic                 full_ff, full_in;

   node_type             word;
   node_type             word_upd;
   logic                 bit_sel;
   logic [IDX_W-1:0]     nxt;
   logic [IDX_W-1:0]     new_idx;
   logic                 at_end;
   logic                 cur_is_root;

   always_comb begin
      cur_is_root = (cur_idx_ff == '0);
      if (cur_is_root) begin
         word = root_ff;
      end else if (rd_pend_ff) begin
         word = node_type'(ram_rdata);
      end else begin
         word = cur_word_ff;
      end
      bit_sel = addr_ff[ADDR_BITS-1];
      nxt     = bit_sel ? word.child1 : word.child0;
      at_end  = (level_ff == limit_ff);
      new_idx = next_free_ff[IDX_W-1:0];
      word_upd = word;
      if (bit_sel) begin
         word_upd.child1 = new_idx;
      end else begin
         word_upd.child0 = new_idx;
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      addr_in      = addr_ff;
      limit_in     = limit_ff;
      level_in     = level_ff;
      cur_idx_in   = cur_idx_ff;
      cur_word_in  = cur_word_ff;
      rd_pend_in   = 1'b0;
      link_word_in = link_word_ff;
      link_idx_in  = link_idx_ff;
      root_in      = root_ff;
      next_free_in = next_free_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      ram_we       = 1'b0;
      ram_addr     = cur_idx_ff;
      ram_wdata    = NODE_W'(word);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in    = cmd.func;
               addr_in    = cmd.addr;
               limit_in   = cmd.limit;
               level_in   = '0;
               cur_idx_in = '0;
               found_in   = 1'b0;
               full_in    = 1'b0;
               state_in   = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (func_ff == FUNC_LOOKUP) begin
               if (word.mark) begin
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else if (at_end || nxt == '0) begin
                  state_in = ST_DONE;
               end else begin
                  // follow the existing branch
                  ram_addr   = nxt;
                  rd_pend_in = 1'b1;
                  cur_idx_in = nxt;
                  level_in   = LVL_W'(level_ff + 1'b1);
                  addr_in    = addr_ff << 1;
               end
            end else begin
               if (at_end) begin
                  // mark the prefix end
                  if (cur_is_root) begin
                     root_in.mark = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_addr  = cur_idx_ff;
                     ram_wdata = NODE_W'({word.child0, word.child1, 1'b1});
                  end
                  state_in = ST_DONE;
               end else if (nxt != '0) begin
                  ram_addr   = nxt;
                  rd_pend_in = 1'b1;
                  cur_idx_in = nxt;
                  level_in   = LVL_W'(level_ff + 1'b1);
                  addr_in    = addr_ff << 1;
               end else if (next_free_ff == FREE_W'(NODES)) begin
                  full_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  // allocate a fresh node, then link it into its parent
                  ram_we       = 1'b1;
                  ram_addr     = new_idx;
                  ram_wdata    = '0;
                  cur_idx_in   = new_idx;
                  cur_word_in  = '0;
                  next_free_in = FREE_W'(next_free_ff + 1'b1);
                  level_in     = LVL_W'(level_ff + 1'b1);
                  addr_in      = addr_ff << 1;
                  if (cur_is_root) begin
                     root_in = word_upd;
                  end else begin
                     link_word_in = word_upd;
                     link_idx_in  = cur_idx_ff;
                     state_in     = ST_LINK;
                  end
               end
            end
         end

         ST_LINK: begin
            ram_we    = 1'b1;
            ram_addr  = link_idx_ff;
            ram_wdata = NODE_W'(link_word_ff);
            state_in  = ST_EVAL;
         end

         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         root_ff      <= '0;
         next_free_ff <= FREE_W'(1);
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         root_ff      <= root_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      limit_ff     <= limit_in;
      level_ff     <= level_in;
      cur_idx_ff   <= cur_idx_in;
      cur_word_ff  <= cur_word_in;
      link_word_ff <= link_word_in;
      link_idx_ff  <= link_idx_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
   end

   assign res.done  = (state_ff == ST_DONE);
   assign res.found = found_ff;
   assign res.full  = full_ff;

endmodule

>>> rtl/binary_trie_prefix_match.sv
// -----------------------------------------------------------------------------
// binary_trie_prefix_match
// IPv4 prefix store and prefix match on a binary trie held in a
// single-port node memory.
//
//   channel | handshake           | payload                              | dir
//   request | req_valid req_ready | req_func req_address req_prefix_len  | in
//   result  | rsp_valid rsp_ready | rsp_found rsp_full_res               | out
//
// One transaction at a time. A lookup walks L trie levels (at most 32),
// reading the node memory once per level through its single port. An
// insert adds a parent link write for each new node whose parent is not
// the root.
// Reset empties the trie at once; no clearing pass is needed.
// A new request is taken while the previous result waits on rsp_ready; the
// walk after it holds its result until that slot frees.
// -----------------------------------------------------------------------------
module binary_trie_prefix_match (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [btpm_pkg::REQ_ADDR_W-1:0] req_address,
   input  logic [btpm_pkg::PLEN_W-1:0]     req_prefix_len,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic                            rsp_full_res
);
   import btpm_pkg::*;

   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              accept;
   logic              ack;
   cmd_type           cmd;
   res_type           res;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [NODE_W-1:0] ram_wdata;
   logic [NODE_W-1:0] ram_rdata;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.func = req_func;
      cmd.addr = ADDR_BITS'(req_address);
      if (req_func == FUNC_LOOKUP) begin
         cmd.limit = LVL_W'(ADDR_BITS);
      end else if (int'(req_prefix_len) > ADDR_BITS) begin
         cmd.limit = LVL_W'(ADDR_BITS);
      end else begin
         cmd.limit = LVL_W'(req_prefix_len);
      end
   end

   // hand the result over once the output slot is free
   assign ack = res.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (ack) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_found_in = res.found;
         rsp_full_in  = res.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_full_res = rsp_full_ff;

   btpm_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .cmd       (cmd),
      .ack       (ack),
      .res       (res),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   btpm_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

>>> sim/binary_trie_prefix_match_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// binary_trie_prefix_match_tb
// Self-checking bench for the binary trie prefix matcher: a short table of
// directed requests, random inserts and lookups clustered around a few
// prefix bases, a run that drains the node pool, then the rows that mark
// the root. Results are checked against the bench's trie or typed row values.
// -----------------------------------------------------------------------------
module binary_trie_prefix_match_tb;
   import btpm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAIN_ITEMS   = 1000;
   localparam int DRAIN_ITEMS  = 180;
   localparam int SETTLE_TICKS = 100;

   typedef struct packed {
      logic found;
      logic full_res;
   } verdict_type;

   typedef struct packed {
      logic                  func;
      logic [REQ_ADDR_W-1:0] addr;
      logic [PLEN_W-1:0]     plen;
      logic                  typed;
      logic                  found;
      logic                  full_res;
   } probe_row_type;

   typedef struct packed {
      logic [REQ_ADDR_W-1:0] addr;
      logic [PLEN_W-1:0]     plen;
   } prefix_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_func;
   logic [REQ_ADDR_W-1:0] req_address;
   logic [PLEN_W-1:0]     req_prefix_len;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_found;
   logic                  rsp_full_res;

   // behavioral trie: node 0 is the root, child index 0 means no child
   logic [IDX_W-1:0] kid0 [NODES];
   logic [IDX_W-1:0] kid1 [NODES];
   logic             prefix_end [NODES];
   int unsigned      pool_next;

   verdict_type    answers_due [$];
   probe_row_type  probe_rows [$];

   int unsigned items_sent;
   int unsigned n_lookup, n_found, n_insert, n_full;
   int unsigned errors;
   int unsigned cycles;
   int unsigned stall_left;
   int unsigned rx_roll;
   verdict_type due;
   logic        hold_rsp;
   logic        steady;

   binary_trie_prefix_match u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_prefix_len (req_prefix_len),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_full_res   (rsp_full_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic trie_insert(input logic [REQ_ADDR_W-1:0] a,
                                        input logic [PLEN_W-1:0] p);
      int  len;
      int  cur;
      int  nxt;
      logic b;
      len = (p > ADDR_BITS) ? ADDR_BITS : int'(p);
      cur = 0;
      for (int lvl = 0; lvl < len; lvl++) begin
         b   = a[ADDR_BITS-1-lvl];
         nxt = b ? int'(kid1[cur]) : int'(kid0[cur]);
         if (nxt == 0) begin
            // pool empty: nodes taken so far stay, nothing gets marked
            if (pool_next >= NODES) return 1'b1;
            nxt = int'(pool_next);
            pool_next++;
            kid0[nxt]       = '0;
            kid1[nxt]       = '0;
            prefix_end[nxt] = 1'b0;
            if (b) kid1[cur] = IDX_W'(nxt);
            else   kid0[cur] = IDX_W'(nxt);
         end
         cur = nxt;
      end
      prefix_end[cur] = 1'b1;
      return 1'b0;
   endfunction

   function automatic logic trie_lookup(input logic [REQ_ADDR_W-1:0] a);
      int cur;
      int nxt;
      cur = 0;
      for (int lvl = 0; lvl < ADDR_BITS; lvl++) begin
         if (prefix_end[cur]) return 1'b1;
         nxt = a[ADDR_BITS-1-lvl] ? int'(kid1[cur]) : int'(kid0[cur]);
         if (nxt == 0) return 1'b0;
         cur = nxt;
      end
      return prefix_end[cur];
   endfunction

   task automatic probe(input logic f, input logic [REQ_ADDR_W-1:0] a,
                        input logic [PLEN_W-1:0] p, input logic typed,
                        input logic found, input logic full_res);
      probe_row_type row;
      row        = '{f, a, p, typed, found, full_res};
      probe_rows = {probe_rows, row};
   endtask

   // Present one transaction, hold it until accepted, then record its verdict.
   task automatic offer(input logic f, input logic [REQ_ADDR_W-1:0] a,
                        input logic [PLEN_W-1:0] p, input logic typed,
                        input logic found, input logic full_res);
      verdict_type v;
      req_valid      <= 1'b1;
      req_func       <= f;
      req_address    <= a;
      req_prefix_len <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (f == FUNC_INSERT) begin
         v.found    = 1'b0;
         v.full_res = trie_insert(a, p);
         n_insert++;
         if (v.full_res) n_full++;
      end else begin
         v.found    = trie_lookup(a);
         v.full_res = 1'b0;
         n_lookup++;
         if (v.found) n_found++;
      end
      if (typed) begin
         v.found    = found;
         v.full_res = full_res;
      end
      answers_due = {answers_due, v};
      items_sent++;
   endtask

   task automatic idle_req(input bit no_gaps);
      int unsigned roll;
      int unsigned n;
      roll = $urandom_range(99);
      if (no_gaps || roll < 65) n = 0;
      else if (roll < 95)       n = $urandom_range(1, 3);
      else                      n = $urandom_range(10, 50);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_answers();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // result side: check, then choose ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result found=%0b full_res=%0b at cycle %0d",
                        rsp_found, rsp_full_res, cycles);
         end else begin
            due = answers_due.pop_front();
            if (rsp_found !== due.found || rsp_full_res !== due.full_res) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: cycle %0d expected found=%0b full_res=%0b, got %0b %0b",
                           cycles, due.found, due.full_res, rsp_found, rsp_full_res);
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rx_roll = $urandom_range(99);
         if (rx_roll < 20) begin
            stall_left = (rx_roll < 17) ? $urandom_range(0, 2) : $urandom_range(15, 60);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycles, answers_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // long receiver hold-off while requests keep coming: fills the block
   initial begin : rsp_hold_off
      hold_rsp <= 1'b0;
      wait (items_sent >= 400);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : stimulus
      logic [REQ_ADDR_W-1:0] bases [8];
      prefix_type            recent [$];
      prefix_type            pick;
      logic [REQ_ADDR_W-1:0] a;
      logic [PLEN_W-1:0]     p;
      int unsigned           roll;
      int                    tail_from;
      bit                    no_gaps;

      req_valid      <= 1'b0;
      req_func       <= FUNC_INSERT;
      req_address    <= '0;
      req_prefix_len <= '0;
      reset          <= 1'b1;
      steady         <= 1'b0;
      items_sent = 0;
      n_lookup   = 0;
      n_found    = 0;
      n_insert   = 0;
      n_full     = 0;
      pool_next     = 1;
      kid0[0]       = '0;
      kid1[0]       = '0;
      prefix_end[0] = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      //     func         address       len  typed found full
      probe(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0);  // empty trie
      probe(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'hC0A8_0000, 6'd16, 1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'hC0A9_0000, 6'd0,  1'b0, 1'b0, 1'b0);  // missing branch
      probe(FUNC_LOOKUP, 32'hC000_0000, 6'd0,  1'b0, 1'b0, 1'b0);  // stops mid walk
      probe(FUNC_INSERT, 32'hC0A8_0000, 6'd16, 1'b0, 1'b0, 1'b0);  // duplicate
      probe(FUNC_LOOKUP, 32'hC0A8_FFFF, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'h0A00_0000, 6'd8,  1'b0, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'h0A0B_0000, 6'd16, 1'b0, 1'b0, 1'b0);  // nested prefix
      probe(FUNC_LOOKUP, 32'h0A0B_0C0D, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'h0AFF_0000, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'h0000_0001, 6'd32, 1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'h0000_0001, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'hAAAA_AAAA, 6'd63, 1'b0, 1'b0, 1'b0);  // length saturates
      probe(FUNC_LOOKUP, 32'hAAAA_AAAA, 6'd0,  1'b0, 1'b0, 1'b0);
      probe(FUNC_INSERT, 32'h5555_5555, 6'd33, 1'b0, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'h5555_5554, 6'd0,  1'b0, 1'b0, 1'b0);
      // marking the root matches everything, so these rows run last
      tail_from = probe_rows.size();
      probe(FUNC_INSERT, 32'h5A5A_A5A5, 6'd0,  1'b1, 1'b0, 1'b0);
      probe(FUNC_LOOKUP, 32'h1234_5678, 6'd0,  1'b1, 1'b1, 1'b0);
      probe(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0);
      probe(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b0);

      for (int i = 0; i < tail_from; i++) begin
         offer(probe_rows[i].func, probe_rows[i].addr, probe_rows[i].plen,
               probe_rows[i].typed, probe_rows[i].found, probe_rows[i].full_res);
         idle_req(1'b0);
      end
      wait_answers();

      // clustered traffic: prefixes and lookups around a few bases
      foreach (bases[k]) bases[k] = $urandom;
      for (int n = 0; n < MAIN_ITEMS; n++) begin
         no_gaps = (n >= 600 && n < 700);
         steady <= no_gaps;
         roll = $urandom_range(99);
         a    = bases[$urandom_range(7)];
         if (roll < 40) begin
            roll = $urandom_range(99);
            if (roll < 78) begin
               a = a ^ ($urandom & 32'h0000_0FFF);
               p = PLEN_W'($urandom_range(8, 24));
            end else if (roll < 86) begin
               a = a ^ ($urandom & 32'h0000_0FFF);
               p = PLEN_W'($urandom_range(25, 32));
            end else if (roll < 92) begin
               a = a ^ ($urandom & 32'h0000_0FFF);
               p = PLEN_W'($urandom_range(33, 63));
            end else begin
               a = $urandom;
               p = PLEN_W'($urandom_range(10, 20));
            end
            offer(FUNC_INSERT, a, p, 1'b0, 1'b0, 1'b0);
         end else begin
            roll = $urandom_range(99);
            if (roll < 50)      a = a ^ ($urandom & 32'h0000_0FFF);
            else if (roll < 75) a = a ^ (32'h1 << $urandom_range(8, 31));
            else                a = $urandom;
            offer(FUNC_LOOKUP, a, PLEN_W'($urandom), 1'b0, 1'b0, 1'b0);
         end
         idle_req(no_gaps);
      end
      steady <= 1'b0;
      wait_answers();

      // long random prefixes mixed with retries and lookups, to run the pool dry
      for (int n = 0; n < DRAIN_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (roll < 50 || recent.size() == 0) begin
            pick.addr = $urandom;
            pick.plen = PLEN_W'($urandom_range(24, 32));
            recent    = {recent, pick};
            offer(FUNC_INSERT, pick.addr, pick.plen, 1'b0, 1'b0, 1'b0);
         end else if (roll < 70) begin
            pick = recent[$urandom_range(recent.size() - 1)];
            offer(FUNC_INSERT, pick.addr, pick.plen, 1'b0, 1'b0, 1'b0);
         end else begin
            pick = recent[$urandom_range(recent.size() - 1)];
            offer(FUNC_LOOKUP, pick.addr ^ ($urandom & 32'h0000_00FF),
                  PLEN_W'($urandom), 1'b0, 1'b0, 1'b0);
         end
         idle_req(1'b0);
      end
      wait_answers();

      for (int i = tail_from; i < probe_rows.size(); i++) begin
         offer(probe_rows[i].func, probe_rows[i].addr, probe_rows[i].plen,
               probe_rows[i].typed, probe_rows[i].found, probe_rows[i].full_res);
         idle_req(1'b0);
      end
      wait_answers();
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Run: %0d requests, %0d lookups (%0d matched), %0d inserts (%0d refused)",
               items_sent, n_lookup, n_found, n_insert, n_full);
      $display("Trie nodes in use: %0d of %0d, mismatches: %0d", pool_next, NODES, errors);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
